// ===== sv/lph_pkg.sv =====
// Shared types and constants for the LCG password hash block.
// No dependencies; compiled first.
`default_nettype none

package lph_pkg;

    // Seed value after reset and after every finalization
    localparam logic [31:0] SEED_INIT = 32'hDEADBEEF;
    // Byte fold multiplier: seed*131 + byte
    localparam logic [31:0] FOLD_MUL  = 32'd131;
    // Generator: x = 1103515245*x + 12345
    localparam logic [31:0] GEN_MUL   = 32'd1103515245;
    localparam logic [31:0] GEN_ADD   = 32'd12345;

    // Generator steps thrown away before the first digest byte
    localparam int WARMUP_STEPS = 32;
    localparam int WARM_W       = $clog2(WARMUP_STEPS);
    // Generator steps skipped after each digest byte
    localparam int SKIP_STEPS   = 3;
    localparam int PHASE_W      = 2;

    // Operation selected in the shared multiply-add unit
    typedef enum logic {
        MODE_FOLD,
        MODE_GEN
    } mac_mode_t;

endpackage : lph_pkg

`default_nettype wire

// ===== sv/lph_if.sv =====
// Valid/ready channel interfaces for message bytes and digest bytes.
// No dependencies.
`default_nettype none

interface lph_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_valid,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input end_of_message, output ready);
endinterface : lph_msg_if

interface lph_digest_if;
    logic       valid;
    logic       ready;
    logic [7:0] hash_byte;
    logic       last_hash_byte;

    modport source (output valid, output hash_byte, output last_hash_byte,
                    input ready);
    modport sink   (input valid, input hash_byte, input last_hash_byte,
                    output ready);
endinterface : lph_digest_if

`default_nettype wire

// ===== sv/lph_mac.sv =====
// Shared 32-bit multiply-add unit: byte fold or one generator step.
// Depends on lph_pkg.
`default_nettype none

module lph_mac (
    input  wire lph_pkg::mac_mode_t mode,
    input  wire logic [31:0]        x,
    input  wire logic [7:0]         data_byte,
    output logic [31:0]             result
);
    import lph_pkg::*;

    logic [31:0] mul_op;
    logic [31:0] add_op;
    logic [31:0] product;

    // Operand select per mode
    always_comb
    begin
        unique case (mode)
            MODE_FOLD:
            begin
                mul_op = FOLD_MUL;
                add_op = {24'd0, data_byte};
            end
            MODE_GEN:
            begin
                mul_op = GEN_MUL;
                add_op = GEN_ADD;
            end
            default:
            begin
                mul_op = GEN_MUL;
                add_op = GEN_ADD;
            end
        endcase
    end

    // Low 32 bits of product plus addend (mod 2^32)
    assign product = x * mul_op;
    assign result  = product + add_op;

endmodule : lph_mac

`default_nettype wire

// ===== sv/lcg_password_hash_core.sv =====
// LCG password hash: absorbs bytes into a seed, then emits a digest.
// A final item holds ready low through WARMUP_STEPS warm-up steps and then the digest:
// each byte is an emit step followed, but for the last byte, by SKIP_STEPS skip steps
// (one generator step per cycle through the shared multiply-add unit, while the emit
// step waits for a free output slot). Throughput: 1 byte/cycle while absorbing.
// Reset: seed = 0xDEADBEEF, idle. Depends on lph_pkg, lph_if, lph_mac.
`default_nettype none

module lcg_password_hash_core #(
    parameter int DIGEST_BYTES = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    lph_msg_if.sink       msg,
    lph_digest_if.source  digest
);
    import lph_pkg::*;

    localparam int IDX_W = (DIGEST_BYTES > 1) ? $clog2(DIGEST_BYTES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGEST_BYTES - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WARM  = 2'd1;
    localparam logic [1:0] S_BYTES = 2'd2;

    logic [1:0]         state_reg,  state_next;
    logic [31:0]        x_reg,      x_next;
    logic [WARM_W-1:0]  warm_reg,   warm_next;
    logic [PHASE_W-1:0] phase_reg,  phase_next;
    logic [IDX_W-1:0]   idx_reg,    idx_next;
    logic [7:0]         acc_reg,    acc_next;
    logic               oval_reg,   oval_next;
    logic [7:0]         ohash_reg,  ohash_next;
    logic               olast_reg,  olast_next;

    mac_mode_t   mode;
    logic [31:0] mac_out;
    logic        msg_xfer;
    logic        slot_free;
    logic [7:0]  gen_b;

    lph_mac u_mac (
        .mode      (mode),
        .x         (x_reg),
        .data_byte (msg.data_byte),
        .result    (mac_out)
    );

    assign mode      = (state_reg == S_IDLE) ? MODE_FOLD : MODE_GEN;
    assign msg.ready = (state_reg == S_IDLE);
    assign msg_xfer  = msg.valid && msg.ready;
    assign slot_free = !oval_reg || digest.ready;
    assign gen_b     = mac_out[7:0];

    assign digest.valid          = oval_reg;
    assign digest.hash_byte      = ohash_reg;
    assign digest.last_hash_byte = olast_reg;

    // Sequencer: absorb, warm up, then emit with skips
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        warm_next  = warm_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        oval_next  = oval_reg && !digest.ready;
        ohash_next = ohash_reg;
        olast_next = olast_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (msg_xfer)
                begin
                    if (msg.byte_valid)
                    begin
                        x_next = mac_out;
                    end
                    if (msg.end_of_message)
                    begin
                        state_next = S_WARM;
                        warm_next  = '0;
                        acc_next   = '0;
                    end
                end
            end
            S_WARM:
            begin
                x_next    = mac_out;
                warm_next = warm_reg + 1'b1;
                if (warm_reg == WARM_W'(WARMUP_STEPS - 1))
                begin
                    state_next = S_BYTES;
                    phase_next = '0;
                    idx_next   = '0;
                end
            end
            S_BYTES:
            begin
                if (phase_reg == '0)
                begin
                    // Emit step: hash byte is the accumulator before this b
                    if (slot_free)
                    begin
                        oval_next  = 1'b1;
                        ohash_next = acc_reg;
                        olast_next = (idx_reg == LAST_IDX);
                        acc_next   = acc_reg ^ gen_b;
                        if (idx_reg == LAST_IDX)
                        begin
                            state_next = S_IDLE;
                            x_next     = SEED_INIT;
                        end
                        else
                        begin
                            x_next     = mac_out;
                            phase_next = phase_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    // Skip steps
                    x_next = mac_out;
                    if (phase_reg == PHASE_W'(SKIP_STEPS))
                    begin
                        phase_next = '0;
                        idx_next   = idx_reg + 1'b1;
                    end
                    else
                    begin
                        phase_next = phase_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
                x_next     = SEED_INIT;
            end
        endcase
    end

    // Control and seed registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            x_reg     <= SEED_INIT;
            warm_reg  <= '0;
            phase_reg <= '0;
            idx_reg   <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            warm_reg  <= warm_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            oval_reg  <= oval_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        ohash_reg <= ohash_next;
        olast_reg <= olast_next;
    end

endmodule : lcg_password_hash_core

`default_nettype wire

// ===== sim/lcg_password_hash_core_tb.sv =====
// Testbench for lcg_password_hash_core: drives message bytes, predicts each digest
// and checks every digest byte in order. Depends on lph_pkg, lph_if and the core.

module lcg_password_hash_core_tb;

    import lph_pkg::*;

    localparam int          DIGEST_BYTES   = 32;
    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int unsigned HOLDOFF_CYCLES = 450;
    localparam int unsigned DRAIN_CYCLES   = 200;
    localparam int unsigned PHASE_ITEMS    = 82;

    // Digest predictor and in-order result check
    class digest_checker;

        typedef struct packed {
            logic [7:0] hash_byte;
            logic       last_hash_byte;
        } digest_beat_t;

        logic [31:0]  seed;
        digest_beat_t pending_digest[$];
        int unsigned  failures;

        function new();
            seed     = SEED_INIT;
            failures = 0;
        endfunction

        function logic [31:0] lcg_step(logic [31:0] x);
            return x * GEN_MUL + GEN_ADD;
        endfunction

        // Fold one accepted message transfer; a final one queues the full digest
        function void absorb_item(logic [7:0] data_byte, logic byte_valid,
                                  logic end_of_message);
            logic [31:0]  gen;
            logic [7:0]   acc;
            logic [7:0]   b;
            digest_beat_t beat;
            if (byte_valid)
                seed = seed * FOLD_MUL + 32'(data_byte);
            if (!end_of_message)
                return;
            gen = seed;
            acc = 8'h00;
            repeat (WARMUP_STEPS) gen = lcg_step(gen);
            for (int i = 0; i < DIGEST_BYTES; i++)
            begin
                gen = lcg_step(gen);
                b   = gen[7:0];
                acc = acc ^ b;
                repeat (SKIP_STEPS) gen = lcg_step(gen);
                beat.hash_byte      = b ^ acc;
                beat.last_hash_byte = (i == DIGEST_BYTES - 1);
                pending_digest.insert(pending_digest.size(), beat);
            end
            seed = SEED_INIT;
        endfunction

        // Compare one accepted digest transfer with the oldest expected byte
        function void check_digest_byte(logic [7:0] hash_byte, logic last_hash_byte);
            digest_beat_t want;
            if (pending_digest.size() == 0)
            begin
                $error("unexpected digest byte: hash_byte=%02h last_hash_byte=%0b",
                       hash_byte, last_hash_byte);
                failures++;
                return;
            end
            want = pending_digest.pop_front();
            if (hash_byte !== want.hash_byte)
            begin
                $error("hash_byte: expected %02h, actual %02h", want.hash_byte, hash_byte);
                failures++;
            end
            if (last_hash_byte !== want.last_hash_byte)
            begin
                $error("last_hash_byte: expected %0b, actual %0b",
                       want.last_hash_byte, last_hash_byte);
                failures++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_digest.size();
        endfunction

    endclass

    logic clk = 1'b0;
    logic rst_n;

    lph_msg_if    msg_if ();
    lph_digest_if dig_if ();

    lcg_password_hash_core #(
        .DIGEST_BYTES(DIGEST_BYTES)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if),
        .digest(dig_if)
    );

    digest_checker checker_h = new();

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned holdoff_requests;
    int unsigned counted_items;

    // Clock: period 8
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Cycle watchdog
    initial
    begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Digest receiver: random stalls plus requested long hold-offs
    initial
    begin : digest_receiver
        int unsigned hold_left;
        int unsigned holdoffs_served;
        hold_left       = 0;
        holdoffs_served = 0;
        dig_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (dig_if.valid && dig_if.ready)
                checker_h.check_digest_byte(dig_if.hash_byte, dig_if.last_hash_byte);
            if (holdoffs_served != holdoff_requests)
            begin
                holdoffs_served = holdoff_requests;
                hold_left       = HOLDOFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                dig_if.ready <= 1'b0;
            end
            else
                dig_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // One message transfer, with a random idle gap in front of it
    task automatic send_item(input logic [7:0] data_byte, input logic byte_valid,
                             input logic end_of_message);
        int unsigned gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            msg_if.valid          <= 1'b0;
            msg_if.data_byte      <= 8'($urandom);
            msg_if.byte_valid     <= 1'($urandom);
            msg_if.end_of_message <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        msg_if.valid          <= 1'b1;
        msg_if.data_byte      <= data_byte;
        msg_if.byte_valid     <= byte_valid;
        msg_if.end_of_message <= end_of_message;
        @(posedge clk);
        while (!msg_if.ready)
            @(posedge clk);
        checker_h.absorb_item(data_byte, byte_valid, end_of_message);
    endtask

    // Mostly short messages, sometimes long ones, with ignored transfers mixed in
    task automatic send_random_message();
        int unsigned len;
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(7) == 0)
            begin
                send_item(8'($urandom), 1'b0, 1'b0);
                counted_items++;
            end
            send_item(8'($urandom), 1'b1, 1'b0);
            counted_items++;
        end
        send_item(8'($urandom), 1'($urandom_range(3) != 0), 1'b1);
        counted_items++;
    endtask

    task automatic run_phase();
        int unsigned goal;
        goal = counted_items + PHASE_ITEMS;
        while (counted_items < goal)
            send_random_message();
    endtask

    initial
    begin : stimulus
        send_idle_pct    = 23;
        recv_idle_pct    = 66;
        holdoff_requests = 0;
        counted_items    = 0;
        msg_if.valid          <= 1'b0;
        msg_if.data_byte      <= 8'h00;
        msg_if.byte_valid     <= 1'b0;
        msg_if.end_of_message <= 1'b0;
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty message: bare end marker
        send_item(8'hA5, 1'b0, 1'b1);
        // Ignored transfer must not disturb the seed
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // Single-byte messages at both byte extremes
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        // All-ones bytes, then a valid final byte
        repeat (4) send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        // Zero bytes closed by a bare end marker
        repeat (3) send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        // Back-to-back empty messages
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);

        run_phase();

        send_idle_pct = 66;
        recv_idle_pct = 23;
        run_phase();

        // No idling; a long receiver hold-off backs the block up into its input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        holdoff_requests++;
        run_phase();

        msg_if.valid <= 1'b0;
        while (checker_h.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (checker_h.failures == 0 && checker_h.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
